/* hdl/hcd_pkg.sv */
package hcd_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } result_t;

    typedef struct packed {
        logic enable;
        logic data_phase;
        logic left_zero;
    } core_status_t;

    // {is hex digit, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

/* hdl/hcd_core.sv */
module hcd_core #(
    parameter int COUNT_BITS = hcd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_data,
    input  logic                  step,
    input  logic [7:0]            byte_in,
    output logic                  res_valid,
    output hcd_pkg::result_t      res,
    output hcd_pkg::core_status_t status
);

    logic                  enable_reg, enable_next;
    logic                  phase_reg, phase_next;
    logic [COUNT_BITS-1:0] left_reg, left_next;
    logic [COUNT_BITS-1:0] accum_reg, accum_next;
    logic                  seen_reg, seen_next;
    logic                  sad_reg, sad_next;
    logic                  bad_reg, bad_next;

    logic       is_lf;
    logic       is_ws;
    logic [4:0] hex;

    assign is_lf = (byte_in == 8'h0A);
    assign is_ws = (byte_in <= 8'h20) && !is_lf;
    assign hex   = hcd_pkg::hex_digit(byte_in);

    always_comb begin
        enable_next = enable_reg;
        phase_next  = phase_reg;
        left_next   = left_reg;
        accum_next  = accum_reg;
        seen_next   = seen_reg;
        sad_next    = sad_reg;
        bad_next    = bad_reg;
        res_valid   = 1'b0;
        res.data    = 8'h00;
        res.kind    = hcd_pkg::KIND_DATA;

        if (cfg_we) begin
            enable_next = cfg_data;
            left_next   = '0;
            phase_next  = 1'b0;
        end else if (step) begin
            if (!enable_reg) begin
                res_valid = 1'b1;
                res.data  = byte_in;
            end else if (phase_reg) begin
                left_next = left_reg - COUNT_BITS'(1);
                if (left_next == '0) begin
                    phase_next = 1'b0;
                end
                res_valid = 1'b1;
                res.data  = byte_in;
            end else if (is_lf) begin
                accum_next = '0;
                seen_next  = 1'b0;
                sad_next   = 1'b0;
                bad_next   = 1'b0;
                if (bad_reg) begin
                    res_valid = 1'b1;
                    res.kind  = hcd_pkg::KIND_ERROR;
                end else if (seen_reg) begin
                    if (accum_reg == '0) begin
                        res_valid = 1'b1;
                        res.kind  = hcd_pkg::KIND_END;
                    end else begin
                        left_next  = accum_reg;
                        phase_next = 1'b1;
                    end
                end
            end else if (is_ws) begin
                if (seen_reg) begin
                    sad_next = 1'b1;
                end
            end else if (!hex[4]) begin
                bad_next = 1'b1;
            end else if (!bad_reg) begin
                if (sad_reg || (accum_reg[COUNT_BITS-1 -: 4] != 4'd0)) begin
                    bad_next = 1'b1;
                end else begin
                    accum_next = {accum_reg[COUNT_BITS-5:0], hex[3:0]};
                    seen_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            phase_reg  <= 1'b0;
            left_reg   <= '0;
            accum_reg  <= '0;
            seen_reg   <= 1'b0;
            sad_reg    <= 1'b0;
            bad_reg    <= 1'b0;
        end else begin
            enable_reg <= enable_next;
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            accum_reg  <= accum_next;
            seen_reg   <= seen_next;
            sad_reg    <= sad_next;
            bad_reg    <= bad_next;
        end
    end

    assign status.enable     = enable_reg;
    assign status.data_phase = phase_reg;
    assign status.left_zero  = (left_reg == '0);

endmodule

/* hdl/hcd_outbuf.sv */
module hcd_outbuf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  hcd_pkg::result_t in_res,
    output logic             in_ready,
    output logic             out_valid,
    output hcd_pkg::result_t out_res,
    input  logic             out_ready
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    hcd_pkg::result_t out_reg, out_next;
    hcd_pkg::result_t skid_reg, skid_next;

    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_next       = in_res;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

/* hdl/http_chunked_decoder_top.sv */
// HTTP chunked transfer decoder, one body byte per transaction.
// s_ channel: received body bytes. m_ channel: payload bytes and markers,
// m_tuser gives the kind (data, end of body, format error); markers carry
// zero in m_tdata. Size-line bytes give no output, except the LF that ends
// a zero-count line (end of body) or a malformed line (format error).
// cfg_ channel: one-bit chunked enable; 0 passes every byte straight through.
// A write clears any chunk in progress but keeps a partly read size line.
// Write it only while no bytes are in flight; cfg_ready stays low while
// s_tvalid is high, so a write never lands in the cycle of a byte.
// Throughput: one byte per cycle while s_tready is high; the decode state
// updates in the cycle a byte is accepted and its result is registered in
// the output register, or in the skid entry while m_ is stalled.
// Stall: a two-entry output register/skid pair absorbs one extra result;
// s_tready drops only while the skid entry is full.
// Reset (aresetn low, synchronous): enable clears to passthrough, the size
// line state and chunk count clear, both output entries empty.
module http_chunked_decoder_top #(
    parameter int COUNT_BITS = hcd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] kind
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic                  step;
    logic                  res_valid;
    hcd_pkg::result_t      res;
    hcd_pkg::result_t      out_res;
    hcd_pkg::core_status_t status;

    assign cfg_ready = !s_tvalid;
    assign step      = s_tvalid && s_tready;

    hcd_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .step     (step),
        .byte_in  (s_tdata),
        .res_valid(res_valid),
        .res      (res),
        .status   (status)
    );

    hcd_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (step && res_valid),
        .in_res   (res),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_res  (out_res),
        .out_ready(m_tready)
    );

    assign m_tdata = out_res.data;
    assign m_tuser = out_res.kind;

    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != hcd_pkg::KIND_DATA) |-> (m_tdata == 8'h00))
        else $error("marker with nonzero data");

    a_pass_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !cfg_valid && !status.enable) |=> m_tvalid)
        else $error("passthrough byte produced no result");

    a_phase_count: assert property (@(posedge aclk) disable iff (!aresetn)
        status.data_phase |-> !status.left_zero)
        else $error("data phase with zero bytes left");

endmodule
